>>> hw/rtl/nmfw_pkg.sv
// shared types, constants and codes of the nested message frame writer
package nmfw_pkg;

    localparam int BUF_DEPTH   = 4096;
    localparam int STACK_DEPTH = 16;

    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int POS_W      = $clog2(BUF_DEPTH + 1);
    localparam int FIT_W      = POS_W + 1;
    localparam int SP_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int OPEN_W     = $clog2(STACK_DEPTH + 1);
    localparam int VALUE_W    = 64;
    localparam int COUNT_W    = 4;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int VARINT_W   = 32;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_FIXED  = 8;

    typedef enum logic [2:0] {
        KIND_CLEAR  = 3'd0,
        KIND_START  = 3'd1,
        KIND_END    = 3'd2,
        KIND_CANCEL = 3'd3,
        KIND_FIXED  = 3'd4,
        KIND_VARINT = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_CAP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DEEP  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 1'd0,
        CFG_RELIABLE = 1'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        PLAN_SINGLE,
        PLAN_EMIT,
        PLAN_VARINT
    } t_plan;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_EMIT,
        S_VARINT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic emit_step;
        logic var_step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_plan plan;
        logic  slot_free;
        logic  emit_last;
        logic  var_last;
    } t_dp_stat;

endpackage

>>> hw/rtl/nmfw_ctrl.sv
// command sequencer of the nested message frame writer
module nmfw_ctrl import nmfw_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (i_stat.plan)
                    PLAN_SINGLE: begin
                        if (i_stat.slot_free) begin
                            o_cmd.exec = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    PLAN_EMIT: begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_EMIT;
                    end
                    PLAN_VARINT: begin
                        o_cmd.exec = 1'b1;
                        n_state    = S_VARINT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_VARINT: begin
                if (i_stat.slot_free) begin
                    o_cmd.var_step = 1'b1;
                    if (i_stat.var_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/nmfw_datapath.sv
// frame state, message stack, byte emitter and result register
module nmfw_datapath import nmfw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [2:0]            i_kind,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic [COUNT_W-1:0]    i_byte_count,
    input  logic [BYTE_W-1:0]     i_header_code,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_write_valid,
    output logic [ADDR_W-1:0]     o_write_address,
    output logic [BYTE_W-1:0]     o_write_byte,
    output logic [1:0]            o_status,
    output logic [POS_W-1:0]      o_frame_size,
    output logic                  o_last
);

    // configuration
    logic [CFG_DATA_W-1:0] r_capacity;
    logic [BYTE_W-1:0]     r_reliable_code;

    // frame control state
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_used, n_used;
    logic [OPEN_W-1:0] r_open, n_open;
    logic              r_ov, n_ov;

    // command and emitter payload
    logic [2:0]         r_kind;
    logic [COUNT_W-1:0] r_count;
    logic [BYTE_W-1:0]  r_opt;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [COUNT_W-1:0] r_left, n_left;
    logic               r_adv, n_adv;

    // result payload
    logic              r_wv, n_wv;
    logic [ADDR_W-1:0] r_wa, n_wa;
    logic [BYTE_W-1:0] r_wb, n_wb;
    logic [1:0]        r_st, n_st;
    logic [POS_W-1:0]  r_fs, n_fs;
    logic              r_last, n_last;

    // stack of open message starts
    logic [POS_W-1:0] r_stack [STACK_DEPTH];
    logic [POS_W-1:0] r_top;
    logic             push;

    logic [POS_W-1:0]    eff_cap;
    logic [FIT_W-1:0]    pos_ext;
    logic [FIT_W-1:0]    cap_ext;
    logic                fits1, fits3, fitsn;
    logic                stack_full, stack_empty;
    logic [OPEN_W-1:0]   open_dec;
    logic [POS_W-1:0]    clr_pos;
    logic [LEN_W-1:0]    len16;
    logic [VARINT_W-1:0] vcur;
    logic                v_more;
    logic [BYTE_W-1:0]   v_byte;
    logic [POS_W-1:0]    em_end, em_used;
    logic [POS_W-1:0]    var_end, var_used;
    t_plan               plan;
    logic                sgl_wv;
    logic [BYTE_W-1:0]   sgl_wb;
    t_status             sgl_st;
    logic [POS_W-1:0]    sgl_fs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity      <= CFG_DATA_W'(BUF_DEPTH);
            r_reliable_code <= BYTE_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CAPACITY: r_capacity      <= i_cfg_data;
                CFG_RELIABLE: r_reliable_code <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign eff_cap = (r_capacity > POS_W'(BUF_DEPTH)) ? POS_W'(BUF_DEPTH) : r_capacity;
    assign pos_ext = {1'b0, r_pos};
    assign cap_ext = {1'b0, eff_cap};
    assign fits1   = (pos_ext + FIT_W'(1)) <= cap_ext;
    assign fits3   = (pos_ext + FIT_W'(3)) <= cap_ext;
    assign fitsn   = (pos_ext + FIT_W'(r_count)) <= cap_ext;

    assign stack_full  = r_open >= OPEN_W'(STACK_DEPTH);
    assign stack_empty = (r_open == '0);
    assign open_dec    = r_open - OPEN_W'(1);

    assign clr_pos = (r_opt == r_reliable_code) ? POS_W'(3) : POS_W'(1);
    assign len16   = LEN_W'(r_pos) - LEN_W'(r_top) - LEN_W'(3);

    // varint byte from the low seven bits, continuation flag on top
    assign vcur   = r_value[VARINT_W-1:0];
    assign v_more = |vcur[VARINT_W-1:7];
    assign v_byte = {v_more, vcur[6:0]};

    assign em_end   = {1'b0, r_addr} + POS_W'(1);
    assign em_used  = (em_end > r_used) ? em_end : r_used;
    assign var_end  = {1'b0, r_pos[ADDR_W-1:0]} + POS_W'(1);
    assign var_used = (var_end > r_used) ? var_end : r_used;

    // decode of the held command
    always_comb begin
        plan   = PLAN_SINGLE;
        sgl_wv = 1'b0;
        sgl_wb = '0;
        sgl_st = ST_OK;
        sgl_fs = r_used;
        case (r_kind)
            KIND_CLEAR: begin
                sgl_wv = 1'b1;
                sgl_wb = r_opt;
                sgl_fs = clr_pos;
            end
            KIND_START: begin
                if (!fits3) begin
                    sgl_st = ST_CAP;
                end else if (stack_full) begin
                    sgl_st = ST_DEEP;
                end else begin
                    plan = PLAN_EMIT;
                end
            end
            KIND_END: begin
                if (stack_empty) begin
                    sgl_st = ST_EMPTY;
                end else begin
                    plan = PLAN_EMIT;
                end
            end
            KIND_CANCEL: begin
                if (stack_empty) begin
                    sgl_st = ST_EMPTY;
                end else begin
                    sgl_fs = r_top;
                end
            end
            KIND_FIXED: begin
                if (r_count == '0) begin
                    sgl_st = ST_OK;
                end else if (!fitsn) begin
                    sgl_st = ST_CAP;
                end else begin
                    plan = PLAN_EMIT;
                end
            end
            KIND_VARINT: plan = PLAN_VARINT;
            default: ;
        endcase
    end

    always_comb begin
        n_pos   = r_pos;
        n_used  = r_used;
        n_open  = r_open;
        n_value = r_value;
        n_addr  = r_addr;
        n_left  = r_left;
        n_adv   = r_adv;
        n_ov    = r_ov & ~i_out_ready;
        n_wv    = r_wv;
        n_wa    = r_wa;
        n_wb    = r_wb;
        n_st    = r_st;
        n_fs    = r_fs;
        n_last  = r_last;
        push    = 1'b0;

        if (i_cmd.capture) begin
            n_value = i_value;
        end

        if (i_cmd.exec) begin
            if (plan == PLAN_SINGLE) begin
                n_ov   = 1'b1;
                n_wv   = sgl_wv;
                n_wa   = '0;
                n_wb   = sgl_wb;
                n_st   = sgl_st;
                n_fs   = sgl_fs;
                n_last = 1'b1;
            end
            case (r_kind)
                KIND_CLEAR: begin
                    n_open = '0;
                    n_pos  = clr_pos;
                    n_used = clr_pos;
                end
                KIND_START: begin
                    if (plan == PLAN_EMIT) begin
                        push    = 1'b1;
                        n_open  = r_open + OPEN_W'(1);
                        n_value = {{(VALUE_W - 3 * BYTE_W){1'b0}}, r_value[BYTE_W-1:0],
                                   {(2 * BYTE_W){1'b0}}};
                        n_addr  = r_pos[ADDR_W-1:0];
                        n_left  = COUNT_W'(3);
                        n_adv   = 1'b1;
                    end
                end
                KIND_END: begin
                    if (plan == PLAN_EMIT) begin
                        n_open  = open_dec;
                        n_value = {{(VALUE_W - LEN_W){1'b0}}, len16};
                        n_addr  = r_top[ADDR_W-1:0];
                        n_left  = COUNT_W'(2);
                        n_adv   = 1'b0;
                    end
                end
                KIND_CANCEL: begin
                    if (!stack_empty) begin
                        n_open = open_dec;
                        n_pos  = r_top;
                        n_used = r_top;
                    end
                end
                KIND_FIXED: begin
                    n_addr = r_pos[ADDR_W-1:0];
                    n_left = r_count;
                    n_adv  = 1'b1;
                end
                KIND_VARINT: begin
                    n_value = {{(VALUE_W - VARINT_W){1'b0}}, vcur};
                end
                default: ;
            endcase
        end

        if (i_cmd.emit_step) begin
            n_ov    = 1'b1;
            n_wv    = 1'b1;
            n_wa    = r_addr;
            n_wb    = r_value[BYTE_W-1:0];
            n_st    = ST_OK;
            n_fs    = em_used;
            n_last  = (r_left == COUNT_W'(1));
            n_used  = em_used;
            n_value = r_value >> BYTE_W;
            n_addr  = r_addr + ADDR_W'(1);
            n_left  = r_left - COUNT_W'(1);
            if (r_adv) begin
                n_pos = r_pos + POS_W'(1);
            end
        end

        if (i_cmd.var_step) begin
            n_ov = 1'b1;
            if (!fits1) begin
                n_wv   = 1'b0;
                n_wa   = '0;
                n_wb   = '0;
                n_st   = ST_CAP;
                n_fs   = r_used;
                n_last = 1'b1;
            end else begin
                n_wv    = 1'b1;
                n_wa    = r_pos[ADDR_W-1:0];
                n_wb    = v_byte;
                n_st    = ST_OK;
                n_fs    = var_used;
                n_last  = ~v_more;
                n_used  = var_used;
                n_pos   = r_pos + POS_W'(1);
                n_value = r_value >> 7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_used <= '0;
            r_open <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_used <= n_used;
            r_open <= n_open;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_opt   <= i_header_code;
            r_count <= i_byte_count[3] ? COUNT_W'(MAX_FIXED) : i_byte_count;
        end
        r_value <= n_value;
        r_addr  <= n_addr;
        r_left  <= n_left;
        r_adv   <= n_adv;
        r_wv    <= n_wv;
        r_wa    <= n_wa;
        r_wb    <= n_wb;
        r_st    <= n_st;
        r_fs    <= n_fs;
        r_last  <= n_last;
    end

    // stack memory, registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[r_open[SP_W-1:0]] <= r_pos;
        end
        r_top <= r_stack[open_dec[SP_W-1:0]];
    end

    assign o_stat.plan      = plan;
    assign o_stat.slot_free = ~r_ov | i_out_ready;
    assign o_stat.emit_last = (r_left == COUNT_W'(1));
    assign o_stat.var_last  = ~fits1 | ~v_more;

    assign o_out_valid     = r_ov;
    assign o_write_valid   = r_wv;
    assign o_write_address = r_wa;
    assign o_write_byte    = r_wb;
    assign o_status        = r_st;
    assign o_frame_size    = r_fs;
    assign o_last          = r_last;

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= OPEN_W'(STACK_DEPTH))
        else $error("open message count above stack depth");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(BUF_DEPTH))
        else $error("write position beyond buffer");

    a_write_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_wv) |-> (r_fs > {1'b0, r_wa}))
        else $error("byte written outside reported frame size");

    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_st != ST_OK) |-> (!r_wv && r_last))
        else $error("error result carries a write or is not last");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_open != '0))
        else $error("push left the stack empty");

endmodule

>>> hw/rtl/nested_message_frame_writer.sv
// top level of the nested message frame writer: sequencer plus datapath
// a one-result command is captured in idle, then decided, and its result is registered
// from the decide state once the result register is free; a multi-result command passes
// idle, decide and then the emit or varint state, which registers each byte write in turn
// while the result register is free; a new command is taken only back in idle
// synchronous active-low reset: position, used size and open count go to zero,
// capacity to 4096 and reliable code to 1; the start stack is not cleared
module nested_message_frame_writer import nmfw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // command transaction
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_kind,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic [COUNT_W-1:0]    i_byte_count,
    input  logic [BYTE_W-1:0]     i_header_code,
    // result transaction
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_write_valid,
    output logic [ADDR_W-1:0]     o_write_address,
    output logic [BYTE_W-1:0]     o_write_byte,
    output logic [1:0]            o_status,
    output logic [POS_W-1:0]      o_frame_size,
    output logic                  o_last
);

    // command and status between sequencer and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: idle, decide, byte emission, varint emission
    nmfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // datapath: frame state, stack memory, byte shifter and the result register
    // which lets a new command be taken while a result waits downstream
    nmfw_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .i_byte_count    (i_byte_count),
        .i_header_code   (i_header_code),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_write_valid   (o_write_valid),
        .o_write_address (o_write_address),
        .o_write_byte    (o_write_byte),
        .o_status        (o_status),
        .o_frame_size    (o_frame_size),
        .o_last          (o_last)
    );

endmodule

>>> bench/nested_message_frame_writer_checker.sv
// scoreboard that mirrors the frame writer state and checks each result transaction in order
module nested_message_frame_writer_checker import nmfw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_cmd_valid,
    input  logic                  i_cmd_ready,
    input  logic [2:0]            i_kind,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic [COUNT_W-1:0]    i_byte_count,
    input  logic [BYTE_W-1:0]     i_header_code,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic                  i_write_valid,
    input  logic [ADDR_W-1:0]     i_write_address,
    input  logic [BYTE_W-1:0]     i_write_byte,
    input  logic [1:0]            i_status,
    input  logic [POS_W-1:0]      i_frame_size,
    input  logic                  i_last,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_error_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data;
        t_status           status;
        logic [POS_W-1:0]  frame_size;
        logic              last;
    } t_frame_write;

    logic [CFG_DATA_W-1:0] capacity;
    logic [BYTE_W-1:0]     reliable_code;
    logic [POS_W-1:0]      write_pos;
    logic [POS_W-1:0]      used_size;
    logic [POS_W-1:0]      open_starts [STACK_DEPTH];
    logic [OPEN_W-1:0]     open_count;
    t_frame_write          expected_writes [$];
    t_frame_write          staged_write;
    t_frame_write          head;
    bit                    staged_full;
    int                    fail_count;
    int                    checked;
    int                    error_results;

    function automatic bit room_for(input int n);
        int limit;
        limit = (int'(capacity) > BUF_DEPTH) ? BUF_DEPTH : int'(capacity);
        return (int'(write_pos) + n) <= limit;
    endfunction

    // one result of the current command; held back until we know whether it is the final one
    task automatic post_result(input bit wv, input int addr, input logic [BYTE_W-1:0] data,
                               input t_status st);
        int a;
        a = wv ? (addr % BUF_DEPTH) : 0;
        if (wv && (a + 1) > int'(used_size))
            used_size = POS_W'(a + 1);
        if (staged_full)
            expected_writes.push_back(staged_write);
        staged_write.write_valid = wv;
        staged_write.address     = wv ? ADDR_W'(a) : '0;
        staged_write.data        = wv ? data : '0;
        staged_write.status      = st;
        staged_write.frame_size  = used_size;
        staged_write.last        = 1'b0;
        staged_full              = 1'b1;
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] data);
        post_result(1'b1, int'(write_pos), data, ST_OK);
        write_pos = write_pos + 1'b1;
    endtask

    task automatic model_frame_command(input logic [2:0] kind, input logic [VALUE_W-1:0] value,
                                       input logic [COUNT_W-1:0] count_in,
                                       input logic [BYTE_W-1:0] opt);
        int                  n;
        int                  s;
        int                  len;
        logic [VARINT_W-1:0] v;
        logic [BYTE_W-1:0]   b;
        bit                  stop;
        staged_full = 1'b0;
        case (kind)
            KIND_CLEAR: begin
                open_count = '0;
                write_pos  = (opt == reliable_code) ? POS_W'(3) : POS_W'(1);
                used_size  = write_pos;
                post_result(1'b1, 0, opt, ST_OK);
            end
            KIND_START: begin
                if (!room_for(3)) begin
                    post_result(1'b0, 0, '0, ST_CAP);
                end else if (int'(open_count) >= STACK_DEPTH) begin
                    post_result(1'b0, 0, '0, ST_DEEP);
                end else begin
                    open_starts[open_count[SP_W-1:0]] = write_pos;
                    open_count = open_count + 1'b1;
                    put_byte('0);
                    put_byte('0);
                    put_byte(value[BYTE_W-1:0]);
                end
            end
            KIND_END: begin
                if (open_count == '0) begin
                    post_result(1'b0, 0, '0, ST_EMPTY);
                end else begin
                    open_count = open_count - 1'b1;
                    s   = int'(open_starts[open_count[SP_W-1:0]]);
                    len = (int'(write_pos) - s - 3) & 32'hFFFF;
                    // length patch goes in little-endian
                    post_result(1'b1, s, len[7:0], ST_OK);
                    post_result(1'b1, s + 1, len[15:8], ST_OK);
                end
            end
            KIND_CANCEL: begin
                if (open_count == '0) begin
                    post_result(1'b0, 0, '0, ST_EMPTY);
                end else begin
                    open_count = open_count - 1'b1;
                    write_pos  = open_starts[open_count[SP_W-1:0]];
                    used_size  = write_pos;
                    post_result(1'b0, 0, '0, ST_OK);
                end
            end
            KIND_FIXED: begin
                n = (int'(count_in) > MAX_FIXED) ? MAX_FIXED : int'(count_in);
                if (n == 0)
                    post_result(1'b0, 0, '0, ST_OK);
                else if (!room_for(n))
                    post_result(1'b0, 0, '0, ST_CAP);
                else
                    for (int i = 0; i < n; i++)
                        put_byte(value[8*i +: 8]);
            end
            KIND_VARINT: begin
                // each group of seven bits is checked for room on its own
                v    = value[VARINT_W-1:0];
                stop = 1'b0;
                do begin
                    b = {1'b0, v[6:0]};
                    if (v >= 32'h80)
                        b[7] = 1'b1;
                    if (!room_for(1)) begin
                        post_result(1'b0, 0, '0, ST_CAP);
                        stop = 1'b1;
                    end else begin
                        put_byte(b);
                        v = v >> 7;
                    end
                end while (!stop && v != '0);
            end
            default: post_result(1'b0, 0, '0, ST_OK);
        endcase
        staged_write.last = 1'b1;
        expected_writes.push_back(staged_write);
        staged_full = 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: result %0d %s expected 0x%0h actual 0x%0h",
                         $time, checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity      = CFG_DATA_W'(BUF_DEPTH);
            reliable_code = 8'd1;
            write_pos     = '0;
            used_size     = '0;
            open_count    = '0;
            staged_full   = 1'b0;
            expected_writes.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CAPACITY)
                    capacity = i_cfg_data;
                else if (i_cfg_index == CFG_RELIABLE)
                    reliable_code = i_cfg_data[BYTE_W-1:0];
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_writes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 40)
                        $display({"%0t: unexpected result, expected none, ",
                                  "actual addr 0x%0h byte 0x%0h status %0d"},
                                 $time, i_write_address, i_write_byte, i_status);
                end else begin
                    head = expected_writes.pop_front();
                    compare_field("write_valid", 64'(head.write_valid), 64'(i_write_valid));
                    compare_field("write_address", 64'(head.address), 64'(i_write_address));
                    compare_field("write_byte", 64'(head.data), 64'(i_write_byte));
                    compare_field("status", 64'(head.status), 64'(i_status));
                    compare_field("frame_size", 64'(head.frame_size), 64'(i_frame_size));
                    compare_field("last", 64'(head.last), 64'(i_last));
                    if (head.status != ST_OK)
                        error_results++;
                    checked++;
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                model_frame_command(i_kind, i_value, i_byte_count, i_header_code);
        end
        o_fail_count    <= fail_count;
        o_pending       <= expected_writes.size();
        o_checked       <= checked;
        o_error_results <= error_results;
    end

endmodule

>>> bench/nested_message_frame_writer_tb.sv
// testbench top for the nested message frame writer: stimulus, idling and final verdict
module nested_message_frame_writer_tb;
    import nmfw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // kind codes the block has no command for
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 7;

    // register settings and idling style of each random phase
    int phase_cap [PHASES] = '{4096, 40, 3, 8191, 300, 17, 4096};
    int phase_rel [PHASES] = '{1, 0, 255, 90, 1, 195, 0};
    int phase_len [PHASES] = '{55, 40, 25, 45, 55, 30, 31};
    bit phase_tx  [PHASES] = '{1, 1, 1, 0, 1, 1, 0};
    bit phase_rx  [PHASES] = '{1, 1, 1, 0, 1, 0, 1};

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  cmd_valid   = 1'b0;
    logic                  cmd_ready;
    logic [2:0]            kind        = '0;
    logic [VALUE_W-1:0]    value       = '0;
    logic [COUNT_W-1:0]    byte_count  = '0;
    logic [BYTE_W-1:0]     header_code = '0;
    logic                  res_valid;
    logic                  res_ready   = 1'b0;
    logic                  write_valid;
    logic [ADDR_W-1:0]     write_address;
    logic [BYTE_W-1:0]     write_byte;
    logic [1:0]            status;
    logic [POS_W-1:0]      frame_size;
    logic                  last;

    int fail_count;
    int pending;
    int checked;
    int error_results;

    bit tx_throttle    = 1'b1;
    bit rx_throttle    = 1'b1;
    int rx_hold        = 0;
    int open_guess     = 0;
    int items_sent     = 0;
    int settings_used  = 1;
    int quiet_cycles   = 0;

    nested_message_frame_writer uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_valid         (cmd_valid),
        .o_ready         (cmd_ready),
        .i_kind          (kind),
        .i_value         (value),
        .i_byte_count    (byte_count),
        .i_header_code   (header_code),
        .o_valid         (res_valid),
        .i_ready         (res_ready),
        .o_write_valid   (write_valid),
        .o_write_address (write_address),
        .o_write_byte    (write_byte),
        .o_status        (status),
        .o_frame_size    (frame_size),
        .o_last          (last)
    );

    nested_message_frame_writer_checker frame_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_cmd_valid     (cmd_valid),
        .i_cmd_ready     (cmd_ready),
        .i_kind          (kind),
        .i_value         (value),
        .i_byte_count    (byte_count),
        .i_header_code   (header_code),
        .i_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .i_write_valid   (write_valid),
        .i_write_address (write_address),
        .i_write_byte    (write_byte),
        .i_status        (status),
        .i_frame_size    (frame_size),
        .i_last          (last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_error_results (error_results)
    );

    // 8 ns clock
    initial begin
        forever #4 clk = ~clk;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // result side back-pressure, changed on the falling edge only
    always @(negedge clk) begin
        if (!rx_throttle) begin
            res_ready = 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            res_ready = ($urandom_range(0, 99) < 65);
            rx_hold   = res_ready ? $urandom_range(0, 4) : draw_pause();
        end
    end

    // watchdog: too long without any transaction on either channel ends the run
    always @(posedge clk) begin
        if (!rst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles at %0t", quiet_cycles, $time);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one command transaction; entered and left on a falling edge, valid stays up on return
    task automatic send_command(input logic [2:0] k, input logic [VALUE_W-1:0] v,
                                input logic [COUNT_W-1:0] n, input logic [BYTE_W-1:0] opt);
        int gap;
        gap = tx_throttle ? draw_pause() : 0;
        if (gap > 0) begin
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid   = 1'b1;
        kind        = k;
        value       = v;
        byte_count  = n;
        header_code = opt;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // drop valid and let every outstanding result come back before touching registers
    task automatic wait_drained();
        cmd_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic program_settings(input logic [CFG_DATA_W-1:0] cap,
                                    input logic [BYTE_W-1:0] rel);
        t_cfg_index idx;
        idx       = CFG_CAPACITY;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = cap;
        @(negedge clk);
        idx       = CFG_RELIABLE;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(rel);
        @(negedge clk);
        cfg_we    = 1'b0;
        settings_used++;
    endtask

    // mostly well-formed nesting with random content, plus a little noise
    task automatic send_random_command(input logic [BYTE_W-1:0] rel);
        int                 pick;
        logic [2:0]         k;
        logic [VALUE_W-1:0] v;
        logic [COUNT_W-1:0] n;
        logic [BYTE_W-1:0]  opt;
        pick = $urandom_range(0, 99);
        v    = {$urandom(), $urandom()};
        // shorter values so varints of every length show up
        if ($urandom_range(0, 2) == 0)
            v = v >> $urandom_range(0, 63);
        n = COUNT_W'($urandom_range(1, MAX_FIXED));
        if ($urandom_range(0, 11) == 0)
            n = COUNT_W'($urandom_range(0, 15));
        opt = ($urandom_range(0, 1) == 0) ? rel : BYTE_W'($urandom());
        if (pick < 4)
            k = KIND_CLEAR;
        else if (pick < 27)
            k = KIND_START;
        else if (pick < 45)
            k = (open_guess > 0 || pick < 29) ? KIND_END : KIND_FIXED;
        else if (pick < 51)
            k = (open_guess > 0 || pick < 46) ? KIND_CANCEL : KIND_VARINT;
        else if (pick < 74)
            k = KIND_FIXED;
        else if (pick < 96)
            k = KIND_VARINT;
        else if (pick < 98)
            k = ($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
        else
            k = 3'($urandom_range(0, 7));
        // rough idea of the nesting depth, only used to steer the mix
        case (k) inside
            KIND_CLEAR:  open_guess = 0;
            KIND_START:  open_guess++;
            KIND_END,
            KIND_CANCEL: if (open_guess > 0) open_guess--;
            default:     ;
        endcase
        send_command(k, v, n, opt);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: capacity 4096, reliable code 1
        send_command(KIND_CLEAR, '0, 4'd1, 8'd1);                 // reliable three-byte header
        send_command(KIND_CLEAR, '1, 4'd1, 8'd0);                 // plain one-byte header
        send_command(KIND_END, '0, 4'd1, 8'd0);                   // end with nothing open
        send_command(KIND_CANCEL, '0, 4'd1, 8'd0);                // cancel with nothing open
        send_command(KIND_START, '1, 4'd1, 8'd0);                 // tag 0xff
        send_command(KIND_FIXED, '1, 4'd8, 8'd0);                 // widest fixed write
        send_command(KIND_FIXED, '0, 4'd1, 8'd0);                 // narrowest fixed write
        send_command(KIND_FIXED, '1, 4'd0, 8'd0);                 // zero count, no write
        send_command(KIND_FIXED, 64'h0123_4567_89AB_CDEF, 4'd15, 8'hFF);  // count clamps to 8
        send_command(KIND_VARINT, '0, 4'd1, 8'd0);                // single zero byte
        send_command(KIND_VARINT, 64'h7F, 4'd1, 8'd0);            // largest one-byte varint
        send_command(KIND_VARINT, 64'h80, 4'd1, 8'd0);            // smallest two-byte varint
        send_command(KIND_VARINT, '1, 4'd1, 8'd0);                // five bytes, upper half ignored
        send_command(KIND_END, '0, 4'd1, 8'd0);                   // length patch
        send_command(KIND_START, '0, 4'd1, 8'd0);
        send_command(KIND_FIXED, 64'hDEAD_BEEF, 4'd4, 8'd0);
        send_command(KIND_CANCEL, '0, 4'd1, 8'd0);                // roll back the message
        send_command(KIND_SPARE_LO, '1, 4'd8, 8'd0);
        send_command(KIND_SPARE_HI, '0, 4'd8, 8'd0);

        // smallest capacity: start refused, a two-byte fixed write fills the buffer, later writes refused
        wait_drained();
        program_settings(13'd3, 8'd1);
        send_command(KIND_CLEAR, '0, 4'd1, 8'd0);
        send_command(KIND_START, '0, 4'd1, 8'd0);
        send_command(KIND_FIXED, 64'hA55A, 4'd2, 8'd0);
        send_command(KIND_VARINT, 64'd5, 4'd1, 8'd0);
        send_command(KIND_FIXED, 64'h1, 4'd1, 8'd0);

        // varint cut short by capacity, bytes already written stay
        wait_drained();
        program_settings(13'd6, 8'hFF);
        send_command(KIND_CLEAR, '0, 4'd1, 8'hFF);
        send_command(KIND_VARINT, 64'hFFFF_FFFF, 4'd1, 8'd0);

        // nesting one past the stack depth, then unwind it all and one more
        wait_drained();
        program_settings(13'd4096, 8'd0);
        send_command(KIND_CLEAR, '0, 4'd1, 8'd0);
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_command(KIND_START, VALUE_W'(i * 17), 4'd1, 8'd0);
        send_command(KIND_VARINT, 64'h3FFF, 4'd1, 8'd0);
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_command(KIND_END, '0, 4'd1, 8'd0);

        // random phases under different settings and idling styles
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            program_settings(CFG_DATA_W'(phase_cap[p]), BYTE_W'(phase_rel[p]));
            tx_throttle = phase_tx[p];
            rx_throttle = phase_rx[p];
            open_guess  = 0;
            send_command(KIND_CLEAR, {$urandom(), $urandom()}, COUNT_W'($urandom()),
                         BYTE_W'(phase_rel[p]));
            repeat (phase_len[p]) send_random_command(BYTE_W'(phase_rel[p]));
        end

        // drain and leave room for any stray result
        wait_drained();
        repeat (12) @(negedge clk);

        $display("sent %0d commands under %0d register settings", items_sent, settings_used);
        $display("compared %0d results, %0d of them with an error status", checked,
                 error_results);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
